/* rtl/lbmc_pkg.sv */
// Shared types, constants and arithmetic helpers for the D2Q9 collision kernel.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package lbmc_pkg;

    localparam int FRAC_BITS = 30;
    localparam int NDIR      = 9;
    localparam int DATA_W    = 32;

    // Stage indexes of the pipeline. The divider takes one quotient bit a stage.
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int ST_SUM    = 0;
    localparam int ST_PREP   = 1;
    localparam int ST_VEL    = ST_PREP + DIV_STEPS + 1;
    localparam int ST_T      = ST_VEL + 1;
    localparam int ST_TT     = ST_T + 1;
    localparam int ST_POLY   = ST_TT + 1;
    localparam int ST_RP     = ST_POLY + 1;
    localparam int ST_RPS    = ST_RP + 1;
    localparam int ST_FP     = ST_RPS + 1;
    localparam int ST_FEQ    = ST_FP + 1;
    localparam int ST_RLX    = ST_FEQ + 1;
    localparam int ST_OUT    = ST_RLX + 1;
    localparam int LAT       = ST_OUT + 1;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [0:0] {
        REG_RELAX_RATE = 1'b0,
        REG_LID_SPEED  = 1'b1
    } cfg_reg_t;

    localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

    function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
        logic signed [31:0] r;
        if (x > 80'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < 80'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    localparam logic signed [79:0] ONE_L = 80'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE_Q = sat32(ONE_L);
    localparam logic signed [31:0] WEIGHT [NDIR] = '{
        sat32((16 * ONE_L + 18) / 36),
        sat32((4 * ONE_L + 18) / 36), sat32((4 * ONE_L + 18) / 36),
        sat32((4 * ONE_L + 18) / 36), sat32((4 * ONE_L + 18) / 36),
        sat32((ONE_L + 18) / 36), sat32((ONE_L + 18) / 36),
        sat32((ONE_L + 18) / 36), sat32((ONE_L + 18) / 36)
    };

    typedef struct packed {
        logic [NDIR-1:0][31:0] dists;
        logic                  lid;
        logic signed [31:0]    rho;
        logic signed [31:0]    vx;
        logic signed [31:0]    vy;
    } cell_t;

    // One velocity quotient in flight: partial remainder, quotient bits, flags.
    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] quo;
        logic        neg;
        logic        ovf;
        logic        zero;
    } div_t;

    // Momentum m over positive density rho: the quotient |m|*2^F/rho reaches
    // 2^31 exactly when |m| >= 2*rho, so that case saturates up front.
    function automatic div_t div_prep(input logic signed [35:0] m,
                                      input logic signed [31:0] rho);
        div_t        s;
        logic [35:0] a;
        logic        pos;
        pos    = (rho > 32'sd0);
        a      = m[35] ? 36'(-m) : 36'(m);
        s.neg  = m[35];
        s.zero = !pos;
        s.ovf  = ({1'b0, a} >= {4'b0, rho, 1'b0});
        s.rem  = (pos && !s.ovf) ? a[32:0] : '0;
        s.quo  = '0;
        return s;
    endfunction

    function automatic div_t div_step(input div_t s, input logic [30:0] d);
        div_t        o;
        logic        ge;
        logic [32:0] diff;
        ge    = (s.rem >= {2'b0, d});
        diff  = s.rem - {2'b0, d};
        o     = s;
        o.rem = ge ? {diff[31:0], 1'b0} : {s.rem[31:0], 1'b0};
        o.quo = {s.quo[29:0], ge};
        return o;
    endfunction

    function automatic logic signed [31:0] div_final(input div_t s);
        logic signed [31:0] q;
        q = $signed({1'b0, s.quo});
        if (s.zero) begin
            return '0;
        end else if (s.ovf) begin
            return s.neg ? Q_MIN : Q_MAX;
        end
        return s.neg ? -q : q;
    endfunction

    // Signed direction component dir * v, dir in {-1, 0, 1}.
    function automatic logic signed [33:0] dir_term(input int dir,
                                                    input logic signed [31:0] v);
        if (dir == 1) begin
            return 34'(v);
        end else if (dir == -1) begin
            return -34'(v);
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

/* rtl/lbm_d2q9_cell_collision.sv */
// D2Q9 lattice Boltzmann BGK collision, one cell per request.
// The velocity divider is radix-2 (one quotient bit a stage). It takes one
// cell per clock unless m_tready holds the output back; each stage advances
// when it is empty or the next one advances. Reset (aresetn low,
// synchronous) empties the pipeline and loads the default relax_rate and
// lid_speed. Uses lbmc_pkg.
`default_nettype none

module lbm_d2q9_cell_collision (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wen,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // dist_rest, dist_east, dist_north, dist_west, dist_south,
    // dist_ne, dist_nw, dist_sw, dist_se (32 bits each)
    input  wire logic [287:0]  s_tdata,
    // lid_cell
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // new_rest, new_east, new_north, new_west, new_south, new_ne, new_nw,
    // new_sw, new_se, density, vel_x, vel_y (32 bits each)
    output logic [383:0]       m_tdata
);
    import lbmc_pkg::*;

    logic [30:0]        relax_rate_reg;
    logic signed [31:0] lid_speed_reg;
    logic signed [31:0] keep;

    logic  valid_reg [LAT];
    logic  en        [LAT];
    cell_t cell_reg  [LAT];
    cell_t cell_in;
    cell_t vel_cell;

    logic signed [35:0] in_sum, in_mx, in_my;
    logic signed [35:0] mx_reg, my_reg;

    div_t        divx_reg [DIV_STEPS+1];
    div_t        divy_reg [DIV_STEPS+1];
    logic [30:0] dvs_reg  [DIV_STEPS];

    logic signed [31:0] t_reg     [NDIR];
    logic signed [31:0] t2_reg    [NDIR];
    logic signed [63:0] sqx_reg, sqy_reg;
    logic signed [63:0] tt_reg    [NDIR];
    logic signed [31:0] usq_reg;
    logic signed [31:0] poly_reg  [NDIR];
    logic signed [63:0] prod_reg  [NDIR];
    logic signed [31:0] rp_reg    [NDIR];
    logic signed [63:0] wprod_reg [NDIR];
    logic signed [31:0] feq_reg   [NDIR];
    logic signed [31:0] feq2_reg  [NDIR];
    logic signed [63:0] fk_reg    [NDIR];
    logic signed [63:0] fo_reg    [NDIR];
    logic [NDIR-1:0][31:0] new_reg;

    assign keep = sat32(80'(ONE_Q) - 80'($signed({1'b0, relax_rate_reg})));

    // Stall chain: a stage loads when it is empty or its successor loads.
    always_comb begin
        en[LAT-1] = !valid_reg[LAT-1] || m_tready;
        for (int i = LAT - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[ST_SUM];
    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {cell_reg[LAT-1].vy, cell_reg[LAT-1].vx, cell_reg[LAT-1].rho, new_reg};

    always_comb begin
        in_sum = '0;
        in_mx  = '0;
        in_my  = '0;
        for (int k = 0; k < NDIR; k++) begin
            in_sum = in_sum + 36'($signed(s_tdata[32*k +: 32]));
            in_mx  = in_mx + 36'(dir_term(DIR_X[k], $signed(s_tdata[32*k +: 32])));
            in_my  = in_my + 36'(dir_term(DIR_Y[k], $signed(s_tdata[32*k +: 32])));
        end
        cell_in.dists = s_tdata;
        cell_in.lid   = s_tuser;
        cell_in.rho   = s_tuser ? ONE_Q : sat32(80'(in_sum));
        cell_in.vx    = '0;
        cell_in.vy    = '0;
    end

    // Lid cells take the lid velocity instead of the quotient.
    always_comb begin
        vel_cell    = cell_reg[ST_VEL-1];
        vel_cell.vx = cell_reg[ST_VEL-1].lid ? lid_speed_reg
                                             : div_final(divx_reg[DIV_STEPS]);
        vel_cell.vy = cell_reg[ST_VEL-1].lid ? 32'sd0
                                             : div_final(divy_reg[DIV_STEPS]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relax_rate_reg <= 31'd42949673;
            lid_speed_reg  <= 32'sd1073742;
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_wen) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RELAX_RATE: relax_rate_reg <= cfg_wdata[30:0];
                    REG_LID_SPEED:  lid_speed_reg  <= $signed(cfg_wdata);
                    default: ;
                endcase
            end
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < LAT; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            cell_reg[ST_SUM] <= cell_in;
            mx_reg           <= in_mx;
            my_reg           <= in_my;
        end
        for (int i = 1; i < LAT; i++) begin
            if (en[i]) begin
                cell_reg[i] <= (i == ST_VEL) ? vel_cell : cell_reg[i-1];
            end
        end

        if (en[ST_PREP]) begin
            divx_reg[0] <= div_prep(mx_reg, cell_reg[ST_SUM].rho);
            divy_reg[0] <= div_prep(my_reg, cell_reg[ST_SUM].rho);
            dvs_reg[0]  <= (cell_reg[ST_SUM].rho > 32'sd0) ? cell_reg[ST_SUM].rho[30:0]
                                                           : 31'd1;
        end
        for (int j = 1; j <= DIV_STEPS; j++) begin
            if (en[ST_PREP + j]) begin
                divx_reg[j] <= div_step(divx_reg[j-1], dvs_reg[j-1]);
                divy_reg[j] <= div_step(divy_reg[j-1], dvs_reg[j-1]);
                if (j < DIV_STEPS) begin
                    dvs_reg[j] <= dvs_reg[j-1];
                end
            end
        end

        if (en[ST_T]) begin
            sqx_reg <= 64'(cell_reg[ST_VEL].vx) * 64'(cell_reg[ST_VEL].vx);
            sqy_reg <= 64'(cell_reg[ST_VEL].vy) * 64'(cell_reg[ST_VEL].vy);
            for (int k = 0; k < NDIR; k++) begin
                t_reg[k] <= sat32(80'(dir_term(DIR_X[k], cell_reg[ST_VEL].vx)
                                      + dir_term(DIR_Y[k], cell_reg[ST_VEL].vy)));
            end
        end

        if (en[ST_TT]) begin
            usq_reg <= sat32(80'(sqx_reg >>> FRAC_BITS) + 80'(sqy_reg >>> FRAC_BITS));
            for (int k = 0; k < NDIR; k++) begin
                tt_reg[k] <= 64'(t_reg[k]) * 64'(t_reg[k]);
                t2_reg[k] <= t_reg[k];
            end
        end

        if (en[ST_POLY]) begin
            for (int k = 0; k < NDIR; k++) begin
                poly_reg[k] <= sat32(80'(ONE_Q) + 80'sd3 * 80'(t2_reg[k])
                                     + ((80'sd9 * 80'(tt_reg[k] >>> FRAC_BITS)) >>> 1)
                                     - ((80'sd3 * 80'(usq_reg)) >>> 1));
            end
        end

        if (en[ST_RP]) begin
            for (int k = 0; k < NDIR; k++) begin
                prod_reg[k] <= 64'(cell_reg[ST_POLY].rho) * 64'(poly_reg[k]);
            end
        end

        if (en[ST_RPS]) begin
            for (int k = 0; k < NDIR; k++) begin
                rp_reg[k] <= sat32(80'(prod_reg[k] >>> FRAC_BITS));
            end
        end

        if (en[ST_FP]) begin
            for (int k = 0; k < NDIR; k++) begin
                wprod_reg[k] <= 64'(rp_reg[k]) * 64'(WEIGHT[k]);
            end
        end

        if (en[ST_FEQ]) begin
            for (int k = 0; k < NDIR; k++) begin
                feq_reg[k] <= sat32(80'(wprod_reg[k] >>> FRAC_BITS));
            end
        end

        if (en[ST_RLX]) begin
            for (int k = 0; k < NDIR; k++) begin
                fk_reg[k]   <= 64'($signed(cell_reg[ST_FEQ].dists[k])) * 64'(keep);
                fo_reg[k]   <= 64'(feq_reg[k]) * 64'($signed({1'b0, relax_rate_reg}));
                feq2_reg[k] <= feq_reg[k];
            end
        end

        // Lid cells emit the bare equilibrium, others the relaxed value.
        if (en[ST_OUT]) begin
            for (int k = 0; k < NDIR; k++) begin
                new_reg[k] <= cell_reg[ST_RLX].lid ? feq2_reg[k]
                            : sat32((80'(fk_reg[k]) + 80'(fo_reg[k])) >>> FRAC_BITS);
            end
        end
    end

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_lid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cell_reg[LAT-1].lid) |->
            (cell_reg[LAT-1].rho == ONE_Q && cell_reg[LAT-1].vy == 32'sd0))
        else $error("lid cell result without unit density and zero vel_y");

    a_no_density: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !cell_reg[LAT-1].lid && cell_reg[LAT-1].rho <= 32'sd0) |->
            (cell_reg[LAT-1].vx == 32'sd0 && cell_reg[LAT-1].vy == 32'sd0))
        else $error("non-positive density with non-zero velocity");

endmodule

`default_nettype wire
